// ===== hw/rtl/swmm_pkg.sv =====
`default_nettype none
package swmm_pkg;

   // Field widths fixed by the word formats.
   localparam int PRICE_W = 48;
   localparam int CFG_W = 10;
   localparam int CSR_IDX_W = 1;
   localparam int WINDOW_MAX_DEF = 512;

   // Samples at or below this code (0.000001 in Q24.24) are discarded.
   localparam logic [PRICE_W-1:0] DROP_LIMIT = 48'd16;
   localparam logic [CFG_W-1:0] WLEN_RESET = 10'd288;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMBINE_MODE = 1'b1;

   // Combine modes.
   localparam logic MODE_MEAN = 1'b0;
   localparam logic MODE_MEDIAN = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic drop_latch;
      logic rem_run;
      logic rem_end;
      logic ins_start;
      logic ins_run;
      logic ins_end;
      logic div_start;
      logic div_run;
      logic med_a;
      logic med_b;
      logic med_c;
      logic finish;
   } swmm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic keep;
      logic need_drop;
      logic rem_done;
      logic ins_done;
      logic div_done;
      logic mode_median;
      logic odd;
      logic out_free;
   } swmm_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/swmm_if.sv =====
`default_nettype none
interface swmm_req_if;
   import swmm_pkg::*;
   logic valid;
   logic ready;
   logic [PRICE_W-1:0] sample_price;
   modport source (output valid, output sample_price, input ready);
   modport sink (input valid, input sample_price, output ready);
endinterface

interface swmm_rsp_if #(
   parameter int FILL_W = $clog2(swmm_pkg::WINDOW_MAX_DEF + 1)
);
   import swmm_pkg::*;
   logic valid;
   logic ready;
   logic [PRICE_W-1:0] filtered_price;
   logic [FILL_W-1:0] window_fill;
   modport source (output valid, output filtered_price, output window_fill, input ready);
   modport sink (input valid, input filtered_price, input window_fill, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/swmm_ram.sv =====
`default_nettype none
module swmm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/swmm_ctrl.sv =====
`default_nettype none
module swmm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire swmm_pkg::swmm_stat_type stat,
   output swmm_pkg::swmm_cmd_type       cmd
);
   import swmm_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_CHECK      = 12'b0000_0000_0010,
      ST_DROP_LATCH = 12'b0000_0000_0100,
      ST_REM        = 12'b0000_0000_1000,
      ST_INS        = 12'b0000_0001_0000,
      ST_DIV_LOAD   = 12'b0000_0010_0000,
      ST_DIV        = 12'b0000_0100_0000,
      ST_MED_A      = 12'b0000_1000_0000,
      ST_MED_B      = 12'b0001_0000_0000,
      ST_MED_C      = 12'b0010_0000_0000,
      ST_FINISH     = 12'b0100_0000_0000,
      ST_INS_END    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Sequencer: trim oldest samples, insert the new one, then combine.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && stat.keep) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.need_drop) begin
               state_in = ST_DROP_LATCH;
            end else begin
               cmd.ins_start = 1'b1;
               state_in = ST_INS;
            end
         end
         ST_DROP_LATCH: begin
            cmd.drop_latch = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            if (stat.rem_done) begin
               cmd.rem_end = 1'b1;
               state_in = ST_CHECK;
            end else begin
               cmd.rem_run = 1'b1;
            end
         end
         ST_INS: begin
            if (stat.ins_done) begin
               state_in = ST_INS_END;
            end else begin
               cmd.ins_run = 1'b1;
            end
         end
         ST_INS_END: begin
            cmd.ins_end = 1'b1;
            state_in = stat.mode_median ? ST_MED_A : ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_run = 1'b1;
            end
         end
         ST_MED_A: begin
            cmd.med_a = 1'b1;
            state_in = ST_MED_B;
         end
         ST_MED_B: begin
            cmd.med_b = 1'b1;
            state_in = stat.odd ? ST_FINISH : ST_MED_C;
         end
         ST_MED_C: begin
            cmd.med_c = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/swmm_dp.sv =====
`default_nettype none
module swmm_dp #(
   parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF,
   parameter int FILL_W = $clog2(WINDOW_MAX + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [swmm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [swmm_pkg::CFG_W-1:0]      csr_wdata,
   input  wire logic [swmm_pkg::PRICE_W-1:0]    req_sample,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [swmm_pkg::PRICE_W-1:0]         rsp_price,
   output logic [FILL_W-1:0]                    rsp_fill,
   input  wire swmm_pkg::swmm_cmd_type          cmd,
   output swmm_pkg::swmm_stat_type              stat
);
   import swmm_pkg::*;

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int TOT_W = PRICE_W + FILL_W;
   localparam int CNT_W = $clog2(TOT_W + 1);
   localparam int CMP_W = (FILL_W > CFG_W) ? FILL_W : CFG_W;

   // Configuration.
   logic [CFG_W-1:0] wl_ff, wl_in;
   logic mode_ff, mode_in;

   // Window state and per-item working registers.
   logic [PRICE_W-1:0] sample_ff, sample_in, victim_ff, victim_in;
   logic [PRICE_W-1:0] a_ff, a_in, res_ff, res_in;
   logic [FILL_W-1:0] lim_ff, lim_in, fill_ff, fill_in, scan_ff, scan_in;
   logic [AW-1:0] oldest_ff, oldest_in, pidx_ff, pidx_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic pend_ff, pend_in, found_ff, found_in, placed_ff, placed_in;
   logic mlat_ff, mlat_in;

   // Divider.
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [TOT_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Output word register.
   logic out_valid_ff, out_valid_in;
   logic [PRICE_W-1:0] out_price_ff, out_price_in;
   logic [FILL_W-1:0] out_fill_ff, out_fill_in;

   // Memory ports.
   logic a_we, s_we;
   logic [AW-1:0] a_waddr, s_waddr, s_raddr;
   logic [PRICE_W-1:0] s_wdata, a_rdata, s_rdata;

   // Helpers.
   logic [CMP_W-1:0] wl_ext;
   logic [FILL_W-1:0] lim_calc, mid;
   logic [AW:0] ring_sum;
   logic [FILL_W:0] div_r;
   logic [PRICE_W:0] med_sum;

   swmm_ram #(.WIDTH(PRICE_W), .DEPTH(WINDOW_MAX)) u_arrival (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(sample_ff),
      .raddr(oldest_ff), .rdata(a_rdata)
   );

   swmm_ram #(.WIDTH(PRICE_W), .DEPTH(WINDOW_MAX)) u_sorted (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata)
   );

   // Effective window length: zero counts as one, capped at the store size.
   always_comb begin
      wl_ext = CMP_W'(wl_ff);
      if (wl_ff == '0) begin
         lim_calc = FILL_W'(1);
      end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
         lim_calc = FILL_W'(WINDOW_MAX);
      end else begin
         lim_calc = FILL_W'(wl_ext);
      end
      ring_sum = {1'b0, oldest_ff} + {1'b0, fill_ff[AW-1:0]};
      if (ring_sum >= (AW+1)'(WINDOW_MAX)) begin
         ring_sum = ring_sum - (AW+1)'(WINDOW_MAX);
      end
      mid = fill_ff >> 1;
      div_r = {rem_ff, quo_ff[TOT_W-1]};
      med_sum = {1'b0, a_ff} + {1'b0, s_rdata};
   end

   // Status toward the controller.
   always_comb begin
      stat.keep = req_sample > DROP_LIMIT;
      stat.need_drop = fill_ff >= lim_ff;
      stat.rem_done = (scan_ff == fill_ff) && !pend_ff;
      stat.ins_done = placed_ff && !pend_ff;
      stat.div_done = cnt_ff == '0;
      stat.mode_median = mlat_ff == MODE_MEDIAN;
      stat.odd = fill_ff[0];
      stat.out_free = !out_valid_ff || rsp_ready;
   end

   // Datapath next-state logic.
   always_comb begin
      wl_in = wl_ff;
      mode_in = mode_ff;
      sample_in = sample_ff;
      victim_in = victim_ff;
      a_in = a_ff;
      res_in = res_ff;
      lim_in = lim_ff;
      fill_in = fill_ff;
      scan_in = scan_ff;
      oldest_in = oldest_ff;
      pidx_in = pidx_ff;
      total_in = total_ff;
      pend_in = pend_ff;
      found_in = found_ff;
      placed_in = placed_ff;
      mlat_in = mlat_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      out_valid_in = out_valid_ff;
      out_price_in = out_price_ff;
      out_fill_in = out_fill_ff;
      a_we = 1'b0;
      a_waddr = ring_sum[AW-1:0];
      s_we = 1'b0;
      s_waddr = '0;
      s_wdata = sample_ff;
      s_raddr = '0;

      // Register writes.
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: wl_in = csr_wdata;
            CSR_COMBINE_MODE: mode_in = csr_wdata[0];
            default: wl_in = wl_ff;
         endcase
      end

      // Capture a kept sample.
      if (cmd.load) begin
         sample_in = req_sample;
         lim_in = lim_calc;
         mlat_in = mode_ff;
      end

      // Oldest sample read from the arrival ring.
      if (cmd.drop_latch) begin
         victim_in = a_rdata;
         total_in = total_ff - {{FILL_W{1'b0}}, a_rdata};
         scan_in = '0;
         pend_in = 1'b0;
         found_in = 1'b0;
      end

      // Removal pass: entries above the victim move down by one.
      if (cmd.rem_run) begin
         if (scan_ff != fill_ff) begin
            s_raddr = scan_ff[AW-1:0];
            pidx_in = scan_ff[AW-1:0];
            scan_in = scan_ff + 1'b1;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            if (found_ff) begin
               s_we = 1'b1;
               s_waddr = pidx_ff - 1'b1;
               s_wdata = s_rdata;
            end
            if (s_rdata == victim_ff) begin
               found_in = 1'b1;
            end
         end
      end

      if (cmd.rem_end) begin
         oldest_in = (oldest_ff == AW'(WINDOW_MAX - 1)) ? '0 : oldest_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end

      // Append to the arrival ring and start the insertion pass.
      if (cmd.ins_start) begin
         a_we = 1'b1;
         total_in = total_ff + {{FILL_W{1'b0}}, sample_ff};
         scan_in = fill_ff;
         pend_in = 1'b0;
         placed_in = 1'b0;
      end

      // Insertion pass from the top: larger entries move up by one.
      if (cmd.ins_run) begin
         if (!placed_ff && scan_ff != '0) begin
            s_raddr = AW'(scan_ff - 1'b1);
            pidx_in = AW'(scan_ff - 1'b1);
            scan_in = scan_ff - 1'b1;
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && !placed_ff) begin
            s_we = 1'b1;
            s_waddr = pidx_ff + 1'b1;
            if (s_rdata > sample_ff) begin
               s_wdata = s_rdata;
            end else begin
               s_wdata = sample_ff;
               placed_in = 1'b1;
            end
         end else if (!placed_ff && !pend_ff && scan_ff == '0) begin
            s_we = 1'b1;
            s_waddr = '0;
            s_wdata = sample_ff;
            placed_in = 1'b1;
         end
      end

      if (cmd.ins_end) begin
         fill_in = fill_ff + 1'b1;
      end

      // Restoring divider, one quotient bit per cycle.
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = total_ff;
         cnt_in = CNT_W'(TOT_W);
      end
      if (cmd.div_run) begin
         if (div_r >= {1'b0, fill_ff}) begin
            rem_in = FILL_W'(div_r - {1'b0, fill_ff});
            quo_in = {quo_ff[TOT_W-2:0], 1'b1};
         end else begin
            rem_in = div_r[FILL_W-1:0];
            quo_in = {quo_ff[TOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end

      // Median reads: the middle entry, or the two middle entries.
      if (cmd.med_a) begin
         s_raddr = fill_ff[0] ? mid[AW-1:0] : AW'(mid - 1'b1);
      end
      if (cmd.med_b) begin
         a_in = s_rdata;
         res_in = s_rdata;
         s_raddr = mid[AW-1:0];
      end
      if (cmd.med_c) begin
         res_in = med_sum[PRICE_W:1];
      end

      // Output word register.
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_price_in = (mlat_ff == MODE_MEDIAN) ? res_ff : quo_ff[PRICE_W-1:0];
         out_fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WLEN_RESET;
         mode_ff <= MODE_MEAN;
         fill_ff <= '0;
         oldest_ff <= '0;
         total_ff <= '0;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         placed_ff <= 1'b0;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
         scan_ff <= '0;
         mlat_ff <= MODE_MEAN;
      end else begin
         wl_ff <= wl_in;
         mode_ff <= mode_in;
         fill_ff <= fill_in;
         oldest_ff <= oldest_in;
         total_ff <= total_in;
         pend_ff <= pend_in;
         found_ff <= found_in;
         placed_ff <= placed_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
         scan_ff <= scan_in;
         mlat_ff <= mlat_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      victim_ff <= victim_in;
      a_ff <= a_in;
      res_ff <= res_in;
      lim_ff <= lim_in;
      pidx_ff <= pidx_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      out_price_ff <= out_price_in;
      out_fill_ff <= out_fill_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_price = out_price_ff;
   assign rsp_fill = out_fill_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/sliding_window_mean_median.sv =====
`default_nettype none
// Channel    Dir  Payload                          Handshake
// req_chan   in   sample_price[47:0]               valid / ready
// rsp_chan   out  filtered_price[47:0], window_fill valid / ready
// csr_*      in   csr_index, csr_wdata[9:0]        csr_we
//
// One word at a time. A kept sample first trims oldest samples, one scan of the
// sorted store for each sample trimmed, then is inserted, then is combined by a
// restoring division for the mean (one quotient bit per cycle) or by median
// reads. The window holds up to 512 entries by default. A discarded sample is
// accepted without leaving the idle state. Reset is synchronous; both stores
// need no clearing pass. A stalled result waits in the output register while
// the next sample is accepted.
module sliding_window_mean_median #(
   parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF,
   parameter int FILL_W = $clog2(WINDOW_MAX + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   swmm_req_if.sink                            req_chan,
   swmm_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [swmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [swmm_pkg::CFG_W-1:0]     csr_wdata
);
   import swmm_pkg::*;

   swmm_cmd_type cmd;
   swmm_stat_type stat;
   logic [FILL_W-1:0] fill_out;

   swmm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .stat(stat), .cmd(cmd)
   );

   swmm_dp #(.WINDOW_MAX(WINDOW_MAX), .FILL_W(FILL_W)) u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_sample(req_chan.sample_price),
      .rsp_ready(rsp_chan.ready), .rsp_valid(rsp_chan.valid),
      .rsp_price(rsp_chan.filtered_price), .rsp_fill(fill_out),
      .cmd(cmd), .stat(stat)
   );

   assign rsp_chan.window_fill = fill_out;
endmodule
`default_nettype wire
